FILE: rtl/smps_pkg.sv
`timescale 1ns / 1ps

package smps_pkg;

  typedef enum logic [1:0] {
    MODE_INACTIVE = 2'd0,
    MODE_ACTIVE   = 2'd1,
    MODE_ERROR    = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    PH_CHECK  = 2'd0,
    PH_WAIT   = 2'd1,
    PH_DECIDE = 2'd2,
    PH_STOP   = 2'd3
  } phase_t;

  localparam logic [1:0] YEL_OFF  = 2'd0;
  localparam logic [1:0] YEL_PUMP = 2'd1;
  localparam logic [1:0] YEL_REST = 2'd2;

  localparam int unsigned MOIST_W = 10;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned TICKS_W = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_MOIST    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_MOIST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_MAX    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ON_TICKS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_TICKS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_EN      = 3'd5;

  localparam logic [TICKS_W-1:0] CHECK_WAIT    = 24'd10000;
  localparam logic [TICKS_W-1:0] DRY_DONE_WAIT = 24'd2000;

  typedef struct packed {
    logic [MOIST_W-1:0] max_moisture;
    logic [MOIST_W-1:0] target_moisture;
    logic [COUNT_W-1:0] pump_count_max;
    logic [TICKS_W-1:0] pump_on_ticks;
    logic [TICKS_W-1:0] pump_off_ticks;
    logic               auto_enable;
  } cfg_t;

  typedef struct packed {
    mode_t              mode;
    phase_t             phase;
    phase_t             after_phase;
    logic [COUNT_W-1:0] bursts;
    logic               pump;
    logic               red;
    logic               green;
    logic [1:0]         yellow;
  } ctl_t;

endpackage

FILE: rtl/smps_step.sv
`timescale 1ns / 1ps

module smps_step #(
  parameter int unsigned TIMER_BITS = 24
) (
  input  smps_pkg::cfg_t                     cfg,
  input  smps_pkg::ctl_t                     ctl_i,
  input  logic [TIMER_BITS-1:0]              elapsed_i,
  input  logic [TIMER_BITS-1:0]              length_i,
  input  logic                               restart,
  input  logic [smps_pkg::MOIST_W-1:0]       moisture,
  output smps_pkg::ctl_t                     ctl_o,
  output logic [TIMER_BITS-1:0]              elapsed_o,
  output logic [TIMER_BITS-1:0]              length_o
);

  localparam logic [32:0] TMAX = (33'd1 << TIMER_BITS) - 33'd1;

  function automatic logic [TIMER_BITS-1:0] sat_len(input logic [smps_pkg::TICKS_W-1:0] v);
    logic [32:0] w;
    w = {{(33 - smps_pkg::TICKS_W){1'b0}}, v};
    return (w > TMAX) ? TMAX[TIMER_BITS-1:0] : w[TIMER_BITS-1:0];
  endfunction

  logic [TIMER_BITS-1:0] elapsed_inc;

  assign elapsed_inc = (elapsed_i == TMAX[TIMER_BITS-1:0]) ? elapsed_i
                                                           : elapsed_i + 1'b1;

  always_comb begin
    ctl_o     = ctl_i;
    elapsed_o = elapsed_i;
    length_o  = length_i;
    if (restart) begin
      ctl_o.pump   = 1'b0;
      ctl_o.red    = 1'b0;
      ctl_o.yellow = smps_pkg::YEL_OFF;
      ctl_o.phase  = smps_pkg::PH_CHECK;
      ctl_o.green  = cfg.auto_enable;
      ctl_o.mode   = cfg.auto_enable ? smps_pkg::MODE_ACTIVE : smps_pkg::MODE_INACTIVE;
    end else if (ctl_i.mode == smps_pkg::MODE_ACTIVE) begin
      unique case (ctl_i.phase)
        smps_pkg::PH_CHECK: begin
          if (moisture > cfg.max_moisture) begin
            ctl_o.bursts = '0;
            ctl_o.phase  = smps_pkg::PH_DECIDE;
          end else begin
            ctl_o.phase       = smps_pkg::PH_WAIT;
            ctl_o.after_phase = smps_pkg::PH_CHECK;
            length_o          = sat_len(smps_pkg::CHECK_WAIT);
            elapsed_o         = '0;
          end
        end
        smps_pkg::PH_WAIT: begin
          elapsed_o = elapsed_inc;
          if (elapsed_inc >= length_i) begin
            ctl_o.phase = ctl_i.after_phase;
          end
        end
        smps_pkg::PH_DECIDE: begin
          if (moisture > cfg.target_moisture) begin
            if (ctl_i.bursts < cfg.pump_count_max) begin
              ctl_o.pump        = 1'b1;
              ctl_o.yellow      = smps_pkg::YEL_PUMP;
              ctl_o.phase       = smps_pkg::PH_WAIT;
              ctl_o.after_phase = smps_pkg::PH_STOP;
              length_o          = sat_len(cfg.pump_on_ticks);
              elapsed_o         = '0;
            end else begin
              ctl_o.mode   = smps_pkg::MODE_ERROR;
              ctl_o.red    = 1'b1;
              ctl_o.green  = 1'b0;
              ctl_o.yellow = smps_pkg::YEL_OFF;
            end
          end else begin
            ctl_o.yellow      = smps_pkg::YEL_OFF;
            ctl_o.phase       = smps_pkg::PH_WAIT;
            ctl_o.after_phase = smps_pkg::PH_CHECK;
            length_o          = sat_len(smps_pkg::DRY_DONE_WAIT);
            elapsed_o         = '0;
          end
        end
        smps_pkg::PH_STOP: begin
          ctl_o.pump = 1'b0;
          if (ctl_i.bursts != {smps_pkg::COUNT_W{1'b1}}) begin
            ctl_o.bursts = ctl_i.bursts + 1'b1;
          end
          ctl_o.yellow      = smps_pkg::YEL_REST;
          ctl_o.phase       = smps_pkg::PH_WAIT;
          ctl_o.after_phase = smps_pkg::PH_DECIDE;
          length_o          = sat_len(cfg.pump_off_ticks);
          elapsed_o         = '0;
        end
        default: begin
          ctl_o = ctl_i;
        end
      endcase
    end
  end

endmodule

FILE: rtl/soil_moisture_pump_sequencer.sv
`timescale 1ns / 1ps
// Channel | Ports                                   | Accepted when
// input   | in_restart, in_moisture                 | in_valid & in_ready
// result  | out_mode .. out_burst_count             | out_valid & out_ready
// config  | cfg_index, cfg_data                     | cfg_valid & cfg_ready
// One item per cycle unless the result stalls: the tick update is one combinational pass into the state
// registers, which also hold the result shown on the out_ ports.
// A new item is taken in the same cycle the held result is taken, so items flow
// back to back; a stalled result only holds off the input. cfg_ready is always high.
// Synchronous active-low reset loads register defaults and clears all state.

module soil_moisture_pump_sequencer #(
  parameter int unsigned TIMER_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_restart,
  input  logic [smps_pkg::MOIST_W-1:0]        in_moisture,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_mode,
  output logic [1:0]                          out_phase,
  output logic                                out_pump_on,
  output logic                                out_red_led,
  output logic                                out_green_led,
  output logic [1:0]                          out_yellow_led,
  output logic [smps_pkg::COUNT_W-1:0]        out_burst_count,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [smps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [smps_pkg::CFG_DATA_W-1:0]     cfg_data
);

  smps_pkg::cfg_t        cfg_r;
  smps_pkg::ctl_t        ctl_r, ctl_nxt;
  logic [TIMER_BITS-1:0] elapsed_r, elapsed_nxt;
  logic [TIMER_BITS-1:0] length_r, length_nxt;
  logic                  out_valid_r;
  logic                  in_acc;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;

  smps_step #(
    .TIMER_BITS(TIMER_BITS)
  ) u_step (
    .cfg       (cfg_r),
    .ctl_i     (ctl_r),
    .elapsed_i (elapsed_r),
    .length_i  (length_r),
    .restart   (in_restart),
    .moisture  (in_moisture),
    .ctl_o     (ctl_nxt),
    .elapsed_o (elapsed_nxt),
    .length_o  (length_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_moisture    <= 10'd400;
      cfg_r.target_moisture <= 10'd400;
      cfg_r.pump_count_max  <= 8'd5;
      cfg_r.pump_on_ticks   <= 24'd3000;
      cfg_r.pump_off_ticks  <= 24'd3000;
      cfg_r.auto_enable     <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        smps_pkg::REG_MAX_MOIST:    cfg_r.max_moisture    <= cfg_data[smps_pkg::MOIST_W-1:0];
        smps_pkg::REG_TARGET_MOIST: cfg_r.target_moisture <= cfg_data[smps_pkg::MOIST_W-1:0];
        smps_pkg::REG_COUNT_MAX:    cfg_r.pump_count_max  <= cfg_data[smps_pkg::COUNT_W-1:0];
        smps_pkg::REG_ON_TICKS:     cfg_r.pump_on_ticks   <= cfg_data[smps_pkg::TICKS_W-1:0];
        smps_pkg::REG_OFF_TICKS:    cfg_r.pump_off_ticks  <= cfg_data[smps_pkg::TICKS_W-1:0];
        smps_pkg::REG_AUTO_EN:      cfg_r.auto_enable     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.mode        <= smps_pkg::MODE_INACTIVE;
      ctl_r.phase       <= smps_pkg::PH_CHECK;
      ctl_r.after_phase <= smps_pkg::PH_CHECK;
      ctl_r.bursts      <= '0;
      ctl_r.pump        <= 1'b0;
      ctl_r.red         <= 1'b0;
      ctl_r.green       <= 1'b0;
      ctl_r.yellow      <= smps_pkg::YEL_OFF;
      elapsed_r         <= '0;
      length_r          <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      if (in_acc) begin
        ctl_r     <= ctl_nxt;
        elapsed_r <= elapsed_nxt;
        length_r  <= length_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_mode        = ctl_r.mode;
  assign out_phase       = ctl_r.phase;
  assign out_pump_on     = ctl_r.pump;
  assign out_red_led     = ctl_r.red;
  assign out_green_led   = ctl_r.green;
  assign out_yellow_led  = ctl_r.yellow;
  assign out_burst_count = ctl_r.bursts;

endmodule

FILE: rtl/smps_checker.sv
`timescale 1ns / 1ps

module smps_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            in_restart,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [1:0]                      out_mode,
  input logic [1:0]                      out_phase,
  input logic                            out_pump_on,
  input logic                            out_red_led,
  input logic                            out_green_led,
  input logic [1:0]                      out_yellow_led
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_free_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with no result pending");

  a_restart_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_restart |=>
      out_valid && !out_pump_on && !out_red_led && out_yellow_led == smps_pkg::YEL_OFF
      && out_phase == smps_pkg::PH_CHECK && out_mode != smps_pkg::MODE_ERROR)
    else $error("restart result wrong");

  a_red_is_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red_led == (out_mode == smps_pkg::MODE_ERROR)))
    else $error("red led and error mode disagree");

  a_error_pump_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mode == smps_pkg::MODE_ERROR |-> !out_pump_on && !out_green_led)
    else $error("pump or green on in error");

endmodule

bind soil_moisture_pump_sequencer smps_checker u_smps_checker (.*);

FILE: tb/sv/tb_soil_moisture_pump_sequencer.sv
`timescale 1ns / 1ps

module tb_soil_moisture_pump_sequencer;

  localparam int unsigned CYCLE_LIMIT = 50000;

  typedef struct packed {
    logic                         restart;
    logic [smps_pkg::MOIST_W-1:0] moisture;
  } tick_t;

  typedef struct packed {
    smps_pkg::mode_t              mode;
    smps_pkg::phase_t             phase;
    logic                         pump;
    logic                         red;
    logic                         green;
    logic [1:0]                   yellow;
    logic [smps_pkg::COUNT_W-1:0] bursts;
  } tick_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            in_restart = 1'b0;
  logic [smps_pkg::MOIST_W-1:0]    in_moisture = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [1:0]                      out_mode;
  logic [1:0]                      out_phase;
  logic                            out_pump_on;
  logic                            out_red_led;
  logic                            out_green_led;
  logic [1:0]                      out_yellow_led;
  logic [smps_pkg::COUNT_W-1:0]    out_burst_count;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [smps_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [smps_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  soil_moisture_pump_sequencer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_restart     (in_restart),
    .in_moisture    (in_moisture),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_mode       (out_mode),
    .out_phase      (out_phase),
    .out_pump_on    (out_pump_on),
    .out_red_led    (out_red_led),
    .out_green_led  (out_green_led),
    .out_yellow_led (out_yellow_led),
    .out_burst_count(out_burst_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // sequencer copy
  smps_pkg::cfg_t               cfg_q = '{max_moisture: 10'd400, target_moisture: 10'd400,
                                          pump_count_max: 8'd5, pump_on_ticks: 24'd3000,
                                          pump_off_ticks: 24'd3000, auto_enable: 1'b0};
  smps_pkg::mode_t              sim_mode = smps_pkg::MODE_INACTIVE;
  smps_pkg::phase_t             sim_phase = smps_pkg::PH_CHECK;
  smps_pkg::phase_t             sim_after = smps_pkg::PH_CHECK;
  logic [smps_pkg::TICKS_W-1:0] sim_elapsed = '0;
  logic [smps_pkg::TICKS_W-1:0] sim_wait_len = '0;
  logic [smps_pkg::COUNT_W-1:0] sim_bursts = '0;
  logic                         sim_pump = 1'b0;
  logic                         sim_red = 1'b0;
  logic                         sim_green = 1'b0;
  logic [1:0]                   sim_yellow = smps_pkg::YEL_OFF;

  tick_t        ticks_q[$];
  tick_result_t tick_results_q[$];
  tick_t        next_tick;
  tick_result_t predicted;
  tick_result_t want;
  int unsigned  ticks_pushed = 0;
  int unsigned  ticks_taken = 0;
  int unsigned  failures = 0;
  int unsigned  cycle_count = 0;
  int unsigned  tx_gap = 0;
  int unsigned  rx_hold = 0;
  bit           idle_on = 1'b1;
  bit           long_stall_req = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic begin_wait(input logic [smps_pkg::TICKS_W-1:0] len,
                            input smps_pkg::phase_t next);
    sim_phase = smps_pkg::PH_WAIT;
    sim_wait_len = len;
    sim_elapsed = '0;
    sim_after = next;
  endtask

  task automatic advance_tick(input logic restart, input logic [smps_pkg::MOIST_W-1:0] moist,
                              output tick_result_t r);
    if (restart) begin
      sim_pump = 1'b0;
      sim_red = 1'b0;
      sim_green = 1'b0;
      sim_yellow = smps_pkg::YEL_OFF;
      sim_phase = smps_pkg::PH_CHECK;
      if (cfg_q.auto_enable) begin
        sim_mode = smps_pkg::MODE_ACTIVE;
        sim_green = 1'b1;
      end else begin
        sim_mode = smps_pkg::MODE_INACTIVE;
      end
    end else if (sim_mode == smps_pkg::MODE_ACTIVE) begin
      case (sim_phase)
        smps_pkg::PH_CHECK: begin
          if (moist > cfg_q.max_moisture) begin
            sim_bursts = '0;
            sim_phase = smps_pkg::PH_DECIDE;
          end else begin
            begin_wait(smps_pkg::CHECK_WAIT, smps_pkg::PH_CHECK);
          end
        end
        smps_pkg::PH_WAIT: begin
          if (sim_elapsed != {smps_pkg::TICKS_W{1'b1}}) sim_elapsed++;
          if (sim_elapsed >= sim_wait_len) sim_phase = sim_after;
        end
        smps_pkg::PH_DECIDE: begin
          if (moist > cfg_q.target_moisture) begin
            if (sim_bursts < cfg_q.pump_count_max) begin
              sim_pump = 1'b1;
              sim_yellow = smps_pkg::YEL_PUMP;
              begin_wait(cfg_q.pump_on_ticks, smps_pkg::PH_STOP);
            end else begin
              sim_mode = smps_pkg::MODE_ERROR;
              sim_red = 1'b1;
              sim_green = 1'b0;
              sim_yellow = smps_pkg::YEL_OFF;
            end
          end else begin
            sim_yellow = smps_pkg::YEL_OFF;
            begin_wait(smps_pkg::DRY_DONE_WAIT, smps_pkg::PH_CHECK);
          end
        end
        default: begin
          sim_pump = 1'b0;
          if (sim_bursts != {smps_pkg::COUNT_W{1'b1}}) sim_bursts++;
          sim_yellow = smps_pkg::YEL_REST;
          begin_wait(cfg_q.pump_off_ticks, smps_pkg::PH_DECIDE);
        end
      endcase
    end
    r = '{mode: sim_mode, phase: sim_phase, pump: sim_pump, red: sim_red,
          green: sim_green, yellow: sim_yellow, bursts: sim_bursts};
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      failures++;
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        advance_tick(in_restart, in_moisture, predicted);
        tick_results_q.push_back(predicted);
        ticks_taken++;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (ticks_q.size() != 0) begin
          next_tick = ticks_q.pop_front();
          in_valid <= 1'b1;
          in_restart <= next_tick.restart;
          in_moisture <= next_tick.moisture;
          if (idle_on && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(1, 4);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (tick_results_q.size() == 0) begin
          $error("result item with no expected result pending");
          failures++;
        end else begin
          want = tick_results_q.pop_front();
          check_field("out_mode", 32'(want.mode), 32'(out_mode));
          check_field("out_phase", 32'(want.phase), 32'(out_phase));
          check_field("out_pump_on", 32'(want.pump), 32'(out_pump_on));
          check_field("out_red_led", 32'(want.red), 32'(out_red_led));
          check_field("out_green_led", 32'(want.green), 32'(out_green_led));
          check_field("out_yellow_led", 32'(want.yellow), 32'(out_yellow_led));
          check_field("out_burst_count", 32'(want.bursts), 32'(out_burst_count));
        end
      end
      if (rx_hold != 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (long_stall_req) begin
        long_stall_req = 1'b0;
        rx_hold = 199;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        rx_hold = $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_tick(input logic restart, input int unsigned moist);
    ticks_q.push_back('{restart: restart, moisture: moist[smps_pkg::MOIST_W-1:0]});
    ticks_pushed++;
  endtask

  task automatic drain();
    while (ticks_taken != ticks_pushed || tick_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [smps_pkg::CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[smps_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      smps_pkg::REG_MAX_MOIST:    cfg_q.max_moisture = val[smps_pkg::MOIST_W-1:0];
      smps_pkg::REG_TARGET_MOIST: cfg_q.target_moisture = val[smps_pkg::MOIST_W-1:0];
      smps_pkg::REG_COUNT_MAX:    cfg_q.pump_count_max = val[smps_pkg::COUNT_W-1:0];
      smps_pkg::REG_ON_TICKS:     cfg_q.pump_on_ticks = val[smps_pkg::TICKS_W-1:0];
      smps_pkg::REG_OFF_TICKS:    cfg_q.pump_off_ticks = val[smps_pkg::TICKS_W-1:0];
      smps_pkg::REG_AUTO_EN:      cfg_q.auto_enable = val[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  function automatic int unsigned pick_level(input int unsigned mid_lo,
                                             input int unsigned mid_hi);
    int unsigned sel;
    sel = $urandom_range(0, 5);
    if (sel == 0) return 0;
    if (sel == 1) return 1023;
    return $urandom_range(mid_lo, mid_hi);
  endfunction

  function automatic int unsigned pick_ticks();
    int unsigned sel;
    sel = $urandom_range(0, 11);
    if (sel < 2) return 0;
    if (sel == 2) return 24'hFFFFFF;
    return $urandom_range(1, 6);
  endfunction

  // mostly dry enough to keep pumping, or wet enough to end the round
  function automatic int unsigned pick_moisture();
    int unsigned sel;
    int unsigned dry_floor;
    sel = $urandom_range(0, 9);
    dry_floor = 32'((cfg_q.max_moisture > cfg_q.target_moisture) ?
                    cfg_q.max_moisture : cfg_q.target_moisture);
    if (sel < 4 && dry_floor != 1023) return $urandom_range(dry_floor + 1, 1023);
    if (sel < 7) return $urandom_range(0, cfg_q.target_moisture);
    return $urandom_range(0, 1023);
  endfunction

  task automatic random_config();
    int unsigned sel;
    write_reg(smps_pkg::REG_MAX_MOIST, pick_level(200, 800));
    write_reg(smps_pkg::REG_TARGET_MOIST, pick_level(100, 700));
    sel = $urandom_range(0, 7);
    write_reg(smps_pkg::REG_COUNT_MAX,
              (sel == 0) ? 0 : (sel == 1) ? 255 : $urandom_range(1, 4));
    write_reg(smps_pkg::REG_ON_TICKS, pick_ticks());
    write_reg(smps_pkg::REG_OFF_TICKS, pick_ticks());
    write_reg(smps_pkg::REG_AUTO_EN, ($urandom_range(0, 9) != 0) ? 1 : 0);
  endtask

  task automatic random_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned run_len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        push_tick(1'b1, $urandom_range(0, 1023));
        sent++;
        run_len = $urandom_range(4, 40);
        repeat (run_len) begin
          push_tick(1'b0, pick_moisture());
          sent++;
        end
      end else begin
        push_tick(1'($urandom_range(0, 1)), $urandom_range(0, 1023));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // inactive after reset: plain ticks and restart without auto
    push_tick(1'b0, 0);
    push_tick(1'b0, 1023);
    push_tick(1'b1, 1023);
    push_tick(1'b0, 1023);
    drain();

    write_reg(smps_pkg::REG_COUNT_MAX, 2);
    write_reg(smps_pkg::REG_ON_TICKS, 1);
    write_reg(smps_pkg::REG_OFF_TICKS, 0);
    write_reg(smps_pkg::REG_AUTO_EN, 1);
    push_tick(1'b1, 1023);
    push_tick(1'b0, 400);
    push_tick(1'b0, 1023);
    push_tick(1'b1, 0);
    push_tick(1'b0, 401);
    push_tick(1'b0, 1023);
    repeat (3) push_tick(1'b0, 0);
    push_tick(1'b0, 401);
    repeat (3) push_tick(1'b0, 512);
    push_tick(1'b0, 1023);
    push_tick(1'b0, 0);
    push_tick(1'b1, 700);
    push_tick(1'b0, 401);
    push_tick(1'b0, 400);
    push_tick(1'b0, 1023);
    drain();

    // check wait cut short by restart, then dry-done wait
    push_tick(1'b1, 0);
    push_tick(1'b0, 0);
    repeat (20) push_tick(1'b0, $urandom_range(0, 1023));
    push_tick(1'b1, 0);
    push_tick(1'b0, 1023);
    push_tick(1'b0, 0);
    repeat (10) push_tick(1'b0, $urandom_range(0, 1023));
    drain();

    // full round of back-to-back bursts, then error
    write_reg(smps_pkg::REG_MAX_MOIST, 0);
    write_reg(smps_pkg::REG_TARGET_MOIST, 0);
    write_reg(smps_pkg::REG_COUNT_MAX, 12);
    write_reg(smps_pkg::REG_ON_TICKS, 0);
    write_reg(smps_pkg::REG_OFF_TICKS, 0);
    push_tick(1'b1, 0);
    push_tick(1'b0, 1);
    repeat (52) push_tick(1'b0, 1023);
    drain();
    write_reg(smps_pkg::REG_AUTO_EN, 0);
    push_tick(1'b1, 5);
    push_tick(1'b0, 1023);
    drain();

    // saturated timers
    write_reg(smps_pkg::REG_AUTO_EN, 1);
    write_reg(smps_pkg::REG_OFF_TICKS, 24'hFFFFFF);
    push_tick(1'b1, 0);
    repeat (12) push_tick(1'b0, 1023);
    drain();
    write_reg(smps_pkg::REG_ON_TICKS, 24'hFFFFFF);
    write_reg(smps_pkg::REG_MAX_MOIST, 1023);
    write_reg(smps_pkg::REG_TARGET_MOIST, 1023);
    push_tick(1'b1, 0);
    push_tick(1'b0, 1023);
    drain();
    write_reg(smps_pkg::REG_MAX_MOIST, 0);
    write_reg(smps_pkg::REG_TARGET_MOIST, 0);
    push_tick(1'b1, 0);
    repeat (12) push_tick(1'b0, 1023);
    drain();

    for (int p = 0; p < 7; p++) begin
      random_config();
      idle_on = (p < 5) ? ($urandom_range(0, 4) != 0) : 1'b0;
      if (p == 2) long_stall_req = 1'b1;
      random_phase(55);
      drain();
    end

    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
